// File: design/pdq_pkg.sv
// pdq_pkg: shared types and constants for the packet descriptor queue.
// No dependencies; used by packet_descriptor_queue.
package pdq_pkg;

    localparam int DEPTH         = 64;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int NODE_OVERHEAD = 64;
    localparam int BYTES_W       = 31;
    localparam int DUR_TOT_W     = 30;

    typedef enum logic [2:0] {
        CMD_PUT   = 3'd0,
        CMD_GET   = 3'd1,
        CMD_FLUSH = 3'd2,
        CMD_ABORT = 3'd3,
        CMD_START = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ABORTED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic [31:0] handle;
        logic [23:0] size;
        logic [23:0] duration;
        logic [7:0]  stream;
        logic [15:0] serial;
        logic        marker;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// File: design/packet_descriptor_queue.sv
// packet_descriptor_queue: descriptor FIFO with running totals, abort flag and serial.
// Depends on pdq_pkg and pdq_ram.
//
// Commands put, flush, abort and start complete in the idle state; a get passes through
// a read state, as the descriptor memory has a registered read port and the byte and
// duration totals are updated from the entry read back. Input stalls in that read state
// and while a result is held by a stalled output. Every command yields exactly one
// result transfer; count, bytes and duration outputs give the totals after the command.
module packet_descriptor_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_handle_in,
    input  logic [23:0] i_size_in,
    input  logic [23:0] i_duration_in,
    input  logic [7:0]  i_stream_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_handle_out,
    output logic [23:0] o_size_out,
    output logic [23:0] o_duration_out,
    output logic [7:0]  o_stream_out,
    output logic [15:0] o_serial_out,
    output logic        o_marker_out,
    output logic [6:0]  o_count_out,
    output logic [30:0] o_bytes_out,
    output logic [29:0] o_total_duration_out
);

    pdq_pkg::t_state                     r_state, n_state;
    logic [pdq_pkg::PTR_W-1:0]           r_head, n_head;
    logic [pdq_pkg::PTR_W-1:0]           r_tail, n_tail;
    logic [pdq_pkg::CNT_W-1:0]           r_count, n_count;
    logic [pdq_pkg::BYTES_W-1:0]         r_bytes, n_bytes;
    logic [pdq_pkg::DUR_TOT_W-1:0]       r_dur, n_dur;
    logic [15:0]                         r_serial, n_serial;
    logic                                r_abort, n_abort;
    logic                                r_out_valid, n_out_valid;
    pdq_pkg::t_status                    r_status, n_status;
    pdq_pkg::t_entry                     r_res, n_res;

    logic                                w_accept;
    logic                                w_full;
    logic                                w_wr_en;
    pdq_pkg::t_entry                     w_wr_data;
    logic                                w_rd_en;
    pdq_pkg::t_entry                     w_rd_data;

    localparam logic [pdq_pkg::BYTES_W-1:0] OVERHEAD =
        pdq_pkg::BYTES_W'(pdq_pkg::NODE_OVERHEAD);

    pdq_ram #(
        .WIDTH (pdq_pkg::ENTRY_W),
        .DEPTH (pdq_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    assign o_stall  = (r_state == pdq_pkg::S_READ) || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == pdq_pkg::CNT_W'(pdq_pkg::DEPTH));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_dur       = r_dur;
        n_serial    = r_serial;
        n_abort     = r_abort;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_res       = r_res;
        w_wr_en     = 1'b0;
        w_wr_data   = '0;
        w_rd_en     = 1'b0;

        case (r_state)
            pdq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = pdq_pkg::ST_OK;
                    n_res       = '0;
                    case (pdq_pkg::t_cmd'(i_cmd))
                        pdq_pkg::CMD_PUT: begin
                            if (r_abort) begin
                                n_status = pdq_pkg::ST_ABORTED;
                            end else if (w_full) begin
                                n_status = pdq_pkg::ST_FULL;
                            end else begin
                                w_wr_en            = 1'b1;
                                w_wr_data.handle   = i_handle_in;
                                w_wr_data.size     = i_size_in;
                                w_wr_data.duration = i_duration_in;
                                w_wr_data.stream   = i_stream_in;
                                w_wr_data.serial   = r_serial;
                                w_wr_data.marker   = 1'b0;
                                n_tail  = pdq_pkg::next_ptr(r_tail);
                                n_count = r_count + pdq_pkg::CNT_W'(1);
                                n_bytes = r_bytes + pdq_pkg::BYTES_W'(i_size_in) + OVERHEAD;
                                n_dur   = r_dur + pdq_pkg::DUR_TOT_W'(i_duration_in);
                            end
                        end
                        pdq_pkg::CMD_GET: begin
                            if (r_abort) begin
                                n_status = pdq_pkg::ST_ABORTED;
                            end else if (r_count == '0) begin
                                n_status = pdq_pkg::ST_EMPTY;
                            end else begin
                                // result follows once the head entry is back from memory
                                w_rd_en     = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = pdq_pkg::S_READ;
                                n_head      = pdq_pkg::next_ptr(r_head);
                                n_count     = r_count - pdq_pkg::CNT_W'(1);
                            end
                        end
                        pdq_pkg::CMD_FLUSH: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_bytes = '0;
                            n_dur   = '0;
                        end
                        pdq_pkg::CMD_ABORT: begin
                            n_abort = 1'b1;
                        end
                        pdq_pkg::CMD_START: begin
                            n_abort = 1'b0;
                            if (w_full) begin
                                n_status = pdq_pkg::ST_FULL;
                            end else begin
                                n_serial         = r_serial + 16'd1;
                                w_wr_en          = 1'b1;
                                w_wr_data.serial = n_serial;
                                w_wr_data.marker = 1'b1;
                                n_tail  = pdq_pkg::next_ptr(r_tail);
                                n_count = r_count + pdq_pkg::CNT_W'(1);
                                n_bytes = r_bytes + OVERHEAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pdq_pkg::S_READ: begin
                n_state     = pdq_pkg::S_IDLE;
                n_out_valid = 1'b1;
                n_status    = pdq_pkg::ST_OK;
                n_res       = w_rd_data;
                n_bytes     = r_bytes - pdq_pkg::BYTES_W'(w_rd_data.size) - OVERHEAD;
                n_dur       = r_dur - pdq_pkg::DUR_TOT_W'(w_rd_data.duration);
            end
            default: begin
                n_state = pdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdq_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_dur       <= '0;
            r_serial    <= '0;
            r_abort     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_dur       <= n_dur;
            r_serial    <= n_serial;
            r_abort     <= n_abort;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_res    <= n_res;
    end

    // Totals only move on a transfer in, which needs the output free, or in the read
    // state, when no result is shown, so the live totals are those of the result on show.
    assign o_valid              = r_out_valid;
    assign o_status             = r_status;
    assign o_handle_out         = r_res.handle;
    assign o_size_out           = r_res.size;
    assign o_duration_out       = r_res.duration;
    assign o_stream_out         = r_res.stream;
    assign o_serial_out         = r_res.serial;
    assign o_marker_out         = r_res.marker;
    assign o_count_out          = r_count;
    assign o_bytes_out          = r_bytes;
    assign o_total_duration_out = r_dur;

endmodule

// File: design/pdq_ram.sv
// pdq_ram: simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module pdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
